/* rtl/gtj_pkg.sv */
// ---------------------------------------------------------------------------
// Greedy text justifier package
// Shared widths, payload structs and sequencer codes.
// ---------------------------------------------------------------------------
package gtj_pkg;

  localparam int WORD_W             = 8;
  localparam int MAX_LINE_WORDS_DEF = 32;

  localparam logic [WORD_W-1:0] LINE_WIDTH_RST = 8'd80;

  typedef struct packed {
    logic [WORD_W-1:0] word_length;
    logic              final_word;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0] out_length;
    logic [WORD_W-1:0] spaces_after;
    logic              line_end;
    logic              overlong;
    logic              run_last;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_APPEND,
    ST_PREP,
    ST_DIV,
    ST_RD,
    ST_WR,
    ST_OVER
  } state_t;

  // What follows once the held line has been sent
  typedef enum logic [1:0] {
    AFT_DONE,
    AFT_APPEND,
    AFT_OVER
  } after_t;

endpackage

/* rtl/gtj_div.sv */
// ---------------------------------------------------------------------------
// Greedy text justifier divider
// Restoring divider, one quotient bit per cycle; splits the spare columns of
// a line over its gaps.
// ---------------------------------------------------------------------------
module gtj_div #(
  parameter int DVD_W = 8,
  parameter int DVS_W = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVD_W-1:0] quo;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign trial = {rem, quo[DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DVD_W-2:0], ge};
      rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

/* rtl/greedy_text_justifier.sv */
// A word that only joins the line goes through check and append, then ready returns.
// Sending a line passes a setup state, then the divider when the line is fully
// justified, then a buffer read and an output register load for each word.
// An overlong word gets its own result from a separate state; output stalls hold the flow.
// One request in flight at a time; ready is low until all its results are loaded.
// Reset: synchronous; line width returns to 80, the line buffer is empty, no output.
// ---------------------------------------------------------------------------
// Greedy text justifier
// Buffers word lengths of one line and emits them with justified spacing;
// the text's last line and one-word lines are left-aligned.
module greedy_text_justifier #(
  parameter int MAX_LINE_WORDS = gtj_pkg::MAX_LINE_WORDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  gtj_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output gtj_pkg::out_t               out_data,
  input  logic                        cfg_write,
  input  logic [gtj_pkg::WORD_W-1:0]  cfg_data
);

  import gtj_pkg::*;

  localparam int AW    = (MAX_LINE_WORDS > 1) ? $clog2(MAX_LINE_WORDS) : 1;
  localparam int CW    = $clog2(MAX_LINE_WORDS + 1);
  localparam int SUM_W = ((CW > WORD_W) ? CW : WORD_W) + 2;

  state_t            state;
  state_t            state_next;
  after_t            after;
  logic [WORD_W-1:0] line_width;
  logic [CW-1:0]     count;
  logic [WORD_W-1:0] letters;
  logic [CW-1:0]     idx;
  logic              mode_left;
  logic [WORD_W-1:0] in_len;
  logic              in_fin;
  logic [WORD_W-1:0] rd_len;
  logic [WORD_W-1:0] mem [MAX_LINE_WORDS];

  logic              ovl;
  logic              close;
  logic [SUM_W-1:0]  sum;
  logic [WORD_W-1:0] spare;
  logic [CW-1:0]     gaps;
  logic [WORD_W-1:0] pad;
  logic              is_last;
  logic              out_free;
  logic [WORD_W-1:0] word_spaces;
  logic              div_start;
  logic              div_done;
  logic [WORD_W-1:0] quo;
  logic [CW-1:0]     rem;
  logic              out_load;
  logic              mem_we;
  out_t              word_item;
  out_t              ovl_item;

  gtj_div #(
    .DVD_W (WORD_W),
    .DVS_W (CW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (spare),
    .divisor   (gaps),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  assign ovl   = in_len > line_width;
  assign sum   = SUM_W'(letters) + SUM_W'(count) + SUM_W'(in_len);
  assign close = (count != '0) &&
                 ((sum > SUM_W'(line_width)) || (count >= CW'(MAX_LINE_WORDS)));
  assign spare = (line_width >= letters) ? line_width - letters : '0;
  assign gaps  = count - CW'(1);
  assign pad   = (spare >= WORD_W'(gaps)) ? spare - WORD_W'(gaps) : '0;

  assign is_last  = (idx + CW'(1)) == count;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    if (is_last) begin
      word_spaces = mode_left ? pad : '0;
    end else if (mode_left) begin
      word_spaces = WORD_W'(1);
    end else begin
      // leftmost gaps take one extra space each
      word_spaces = quo + WORD_W'(idx < rem);
    end
  end

  always_comb begin
    word_item.out_length   = rd_len;
    word_item.spaces_after = word_spaces;
    word_item.line_end     = is_last;
    word_item.overlong     = 1'b0;
    // a closed line ends the request unless the new word is overlong or also ends the text
    word_item.run_last     = is_last &&
                             ((after == AFT_DONE) || ((after == AFT_APPEND) && !in_fin));

    ovl_item.out_length    = in_len;
    ovl_item.spaces_after  = '0;
    ovl_item.line_end      = 1'b1;
    ovl_item.overlong      = 1'b1;
    ovl_item.run_last      = 1'b1;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (ovl) state_next = (count != '0) ? ST_PREP : ST_OVER;
        else if (close) state_next = ST_PREP;
        else state_next = ST_APPEND;
      end
      ST_APPEND: begin
        state_next = in_fin ? ST_PREP : ST_IDLE;
      end
      ST_PREP: begin
        state_next = mode_left ? ST_RD : ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_next = ST_RD;
      end
      ST_RD: begin
        state_next = ST_WR;
      end
      ST_WR: begin
        if (out_free) begin
          if (is_last) begin
            case (after)
              AFT_OVER:   state_next = ST_OVER;
              AFT_APPEND: state_next = ST_APPEND;
              default:    state_next = ST_IDLE;
            endcase
          end else begin
            state_next = ST_RD;
          end
        end
      end
      ST_OVER: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // strobes
  always_comb begin
    in_ready  = (state == ST_IDLE) && !rst;
    div_start = (state == ST_PREP) && !mode_left;
    out_load  = ((state == ST_WR) || (state == ST_OVER)) && out_free;
    mem_we    = (state == ST_APPEND);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      after      <= AFT_DONE;
      line_width <= LINE_WIDTH_RST;
      count      <= '0;
      letters    <= '0;
      idx        <= '0;
      mode_left  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) line_width <= cfg_data;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        ST_CHECK: begin
          mode_left <= (count == CW'(1));
          after     <= ovl ? AFT_OVER : AFT_APPEND;
        end
        ST_APPEND: begin
          count   <= count + CW'(1);
          letters <= letters + in_len;
          if (in_fin) begin
            mode_left <= 1'b1;
            after     <= AFT_DONE;
          end
        end
        ST_PREP: begin
          idx <= '0;
        end
        ST_WR: begin
          if (out_free) begin
            if (is_last) begin
              // line is out: drop it from the buffer
              count   <= '0;
              letters <= '0;
            end else begin
              idx <= idx + CW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_len <= in_data.word_length;
      in_fin <= in_data.final_word;
    end
    if (mem_we) mem[count[AW-1:0]] <= in_len;
    if (state == ST_RD) rd_len <= mem[idx[AW-1:0]];
    if (out_load) out_data <= (state == ST_OVER) ? ovl_item : word_item;
  end

endmodule

/* rtl/gtj_checker.sv */
// ---------------------------------------------------------------------------
// Greedy text justifier port checker
// Watches the top-level ports over time; bound to the top level below.
// ---------------------------------------------------------------------------
module gtj_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input gtj_pkg::in_t               in_data,
  input logic                       out_valid,
  input logic                       out_ready,
  input gtj_pkg::out_t              out_data,
  input logic                       cfg_write,
  input logic [gtj_pkg::WORD_W-1:0] cfg_data
);

  import gtj_pkg::*;

  // a result offered and not taken must hold
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a request offered and not taken must hold
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("request changed while waiting");

  // one request at a time
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after a request");

  a_overlong_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.overlong |->
      out_data.line_end && out_data.run_last && (out_data.spaces_after == '0))
    else $error("overlong word not placed alone");

  // width changes only while the block is idle
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_write |-> in_ready && !out_valid && !$isunknown(cfg_data))
    else $error("width written while busy");

endmodule

bind greedy_text_justifier gtj_checker u_gtj_checker (.*);
